/* design/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared widths, constants and types of the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int ChanW  = 8;
  localparam int HueW   = 15;
  localparam int SatW   = 13;
  localparam int QuotW  = 13;
  localparam int NumW   = QuotW + ChanW;
  localparam int Lanes  = 2;
  localparam int LaneHue = 0;
  localparam int LaneSat = 1;
  localparam int HueCalcW = 17;

  localparam logic [HueCalcW-1:0] GreenOffset = HueCalcW'(7680);
  localparam logic [HueCalcW-1:0] BlueOffset  = HueCalcW'(15360);
  localparam logic [HueCalcW-1:0] FullTurn    = HueCalcW'(23040);

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // per-item info that rides alongside the divider lanes
  typedef struct packed {
    sector_e            sector;
    logic               neg;
    logic               gray;
    logic [ChanW-1:0]   vmax;
  } side_t;

  // one long-division lane: partial remainder, numerator bits turning into
  // quotient bits, divisor
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuotW-1:0] wq;
    logic [ChanW-1:0] den;
  } div_lane_t;

  typedef div_lane_t [Lanes-1:0] div_lanes_t;

endpackage

/* design/rgbhsv_front.sv */
// ----------------------------------------------------------------------------
// rgbhsv_front
// max/min, sector pick and divider operand setup, one register stage
// ----------------------------------------------------------------------------
module rgbhsv_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rgbhsv_pkg::ChanW-1:0] red_i,
  input  logic [rgbhsv_pkg::ChanW-1:0] green_i,
  input  logic [rgbhsv_pkg::ChanW-1:0] blue_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rgbhsv_pkg::div_lanes_t    lanes_o,
  output rgbhsv_pkg::side_t         side_o
);
  import rgbhsv_pkg::*;

  logic             max_r, max_g;
  logic [ChanW-1:0] vmax, vmin, delta, mag;
  logic [ChanW:0]   diff;
  logic [NumW-1:0]  hue_num, sat_num;
  sector_e          sector;
  div_lanes_t       lanes_d, lanes_q;
  side_t            side_d, side_q;
  logic             vld_q;
  logic             adv;

  always_comb begin
    // red wins ties, then green
    max_r = (red_i >= green_i) && (red_i >= blue_i);
    max_g = !max_r && (green_i >= blue_i);
    vmin  = (red_i <= green_i) ? red_i : green_i;
    vmin  = (blue_i <= vmin) ? blue_i : vmin;
    if (max_r) begin
      sector = SecRed;
      vmax   = red_i;
      diff   = {1'b0, green_i} - {1'b0, blue_i};
    end else if (max_g) begin
      sector = SecGreen;
      vmax   = green_i;
      diff   = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      sector = SecBlue;
      vmax   = blue_i;
      diff   = {1'b0, red_i} - {1'b0, green_i};
    end
    delta = vmax - vmin;
    mag   = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
    // 3840 * mag as 4096 * mag - 256 * mag
    hue_num = NumW'({mag, 12'b0}) - NumW'({mag, 8'b0});
    sat_num = NumW'({delta, 12'b0});

    lanes_d[LaneHue].rem = hue_num[NumW-1:QuotW];
    lanes_d[LaneHue].wq  = hue_num[QuotW-1:0];
    lanes_d[LaneHue].den = delta;
    lanes_d[LaneSat].rem = sat_num[NumW-1:QuotW];
    lanes_d[LaneSat].wq  = sat_num[QuotW-1:0];
    lanes_d[LaneSat].den = vmax;

    side_d.sector = sector;
    side_d.neg    = diff[ChanW];
    side_d.gray   = (delta == '0);
    side_d.vmax   = vmax;
  end

  assign adv        = !vld_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      lanes_q <= lanes_d;
      side_q  <= side_d;
    end
  end

  assign out_valid_o = vld_q;
  assign lanes_o     = lanes_q;
  assign side_o      = side_q;

endmodule

/* design/rgbhsv_div.sv */
// ----------------------------------------------------------------------------
// rgbhsv_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rgbhsv_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rgbhsv_pkg::div_lanes_t lanes_i,
  input  rgbhsv_pkg::side_t      side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rgbhsv_pkg::div_lanes_t lanes_o,
  output rgbhsv_pkg::side_t      side_o
);
  import rgbhsv_pkg::*;

  function automatic div_lane_t div_step(div_lane_t a);
    logic [ChanW:0] t;
    logic [ChanW:0] s;
    div_lane_t      r;
    t     = {a.rem, a.wq[QuotW-1]};
    s     = t - {1'b0, a.den};
    r.den = a.den;
    if (t >= {1'b0, a.den}) begin
      r.rem = s[ChanW-1:0];
      r.wq  = {a.wq[QuotW-2:0], 1'b1};
    end else begin
      r.rem = t[ChanW-1:0];
      r.wq  = {a.wq[QuotW-2:0], 1'b0};
    end
    return r;
  endfunction

  div_lanes_t lanes_q [QuotW];
  side_t      side_q  [QuotW];
  logic       vld_q   [QuotW];
  logic       rdy     [QuotW+1];

  assign rdy[QuotW] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    div_lanes_t lanes_in;
    div_lanes_t lanes_d;
    side_t      side_in;
    logic       vld_in;

    if (k == 0) begin : g_first
      assign lanes_in = lanes_i;
      assign side_in  = side_i;
      assign vld_in   = in_valid_i;
    end else begin : g_next
      assign lanes_in = lanes_q[k-1];
      assign side_in  = side_q[k-1];
      assign vld_in   = vld_q[k-1];
    end

    always_comb begin
      lanes_d[LaneHue] = div_step(lanes_in[LaneHue]);
      lanes_d[LaneSat] = div_step(lanes_in[LaneSat]);
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in) begin
        lanes_q[k] <= lanes_d;
        side_q[k]  <= side_in;
      end
    end
  end

  assign out_valid_o = vld_q[QuotW-1];
  assign lanes_o     = lanes_q[QuotW-1];
  assign side_o      = side_q[QuotW-1];

endmodule

/* design/rgbhsv_back.sv */
// ----------------------------------------------------------------------------
// rgbhsv_back
// floor correction, sector offset, wrap and gray zeroing into output register
// ----------------------------------------------------------------------------
module rgbhsv_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rgbhsv_pkg::div_lanes_t       lanes_i,
  input  rgbhsv_pkg::side_t            side_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rgbhsv_pkg::HueW-1:0]  hue_o,
  output logic [rgbhsv_pkg::SatW-1:0]  saturation_o,
  output logic [rgbhsv_pkg::ChanW-1:0] brightness_o
);
  import rgbhsv_pkg::*;

  logic [HueCalcW-1:0] offset, qc, h0, h1;
  logic [HueW-1:0]     hue_d, hue_q;
  logic [SatW-1:0]     sat_d, sat_q;
  logic [ChanW-1:0]    bri_q;
  logic                vld_q;
  logic                adv;

  always_comb begin
    case (side_i.sector)
      SecRed:   offset = '0;
      SecGreen: offset = GreenOffset;
      SecBlue:  offset = BlueOffset;
      default:  offset = '0;
    endcase
    // negative quotient rounds toward minus infinity: bump magnitude on remainder
    qc = HueCalcW'(lanes_i[LaneHue].wq)
       + HueCalcW'(side_i.neg && (lanes_i[LaneHue].rem != '0));
    h0 = side_i.neg ? (offset - qc) : (offset + qc);
    h1 = h0[HueCalcW-1] ? (h0 + FullTurn) : h0;
    hue_d = side_i.gray ? '0 : h1[HueW-1:0];
    sat_d = side_i.gray ? '0 : lanes_i[LaneSat].wq[SatW-1:0];
  end

  assign adv        = !vld_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= side_i.vmax;
    end
  end

  assign out_valid_o  = vld_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;

endmodule

/* design/rgb_to_hsv.sv */
// stages from input to output (the 13-stage divider sets the depth):
// 1 operand stage, 13 divider stages, 1 output stage
// throughput: one item per cycle while the output is not stalled
// reset: asynchronous active-low reset empties every stage, no item in flight
// ----------------------------------------------------------------------------
// rgb_to_hsv
// pipelined rgb to hsv pixel converter
// ----------------------------------------------------------------------------
module rgb_to_hsv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rgbhsv_pkg::ChanW-1:0] red_i,
  input  logic [rgbhsv_pkg::ChanW-1:0] green_i,
  input  logic [rgbhsv_pkg::ChanW-1:0] blue_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rgbhsv_pkg::HueW-1:0]  hue_o,
  output logic [rgbhsv_pkg::SatW-1:0]  saturation_o,
  output logic [rgbhsv_pkg::ChanW-1:0] brightness_o
);
  import rgbhsv_pkg::*;

  div_lanes_t fr_lanes, dv_lanes;
  side_t      fr_side, dv_side;
  logic       fr_valid, fr_ready, dv_valid, dv_ready;

  rgbhsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .lanes_o     (fr_lanes),
    .side_o      (fr_side)
  );

  rgbhsv_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .lanes_i     (fr_lanes),
    .side_i      (fr_side),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .lanes_o     (dv_lanes),
    .side_o      (dv_side)
  );

  rgbhsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (dv_valid),
    .in_ready_o   (dv_ready),
    .lanes_i      (dv_lanes),
    .side_i       (dv_side),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

endmodule

/* design/rgbhsv_chk.sv */
// ----------------------------------------------------------------------------
// rgbhsv_chk
// port-level checks on the converter's result channel
// ----------------------------------------------------------------------------
module rgbhsv_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [rgbhsv_pkg::HueW-1:0]  hue_o,
  input logic [rgbhsv_pkg::SatW-1:0]  saturation_o,
  input logic [rgbhsv_pkg::ChanW-1:0] brightness_o
);
  import rgbhsv_pkg::*;

  // a stalled item stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hue_o)
      && $stable(saturation_o) && $stable(brightness_o))
    else $error("result item changed while stalled");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hue_o < HueW'(23040))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> saturation_o <= SatW'(4096))
    else $error("saturation above one");

  // zero saturation means a gray pixel, so hue must be zero too
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (saturation_o == '0) |-> hue_o == '0)
    else $error("gray item with nonzero hue");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (brightness_o == '0) |-> saturation_o == '0)
    else $error("black item with nonzero saturation");

endmodule

bind rgb_to_hsv rgbhsv_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .brightness_o (brightness_o)
);

/* bench/rgb_to_hsv_tb.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_tb
// self-checking bench for the rgb to hsv converter: corner pixels, then random
// pixels with random input gaps and output stalls, a drain pause, more random
// pixels; every result is checked field by field against a software conversion
// ----------------------------------------------------------------------------
module rgb_to_hsv_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbhsv_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 30;

  localparam int HueSpan    = 3840;
  localparam int GreenStart = 7680;
  localparam int BlueStart  = 15360;
  localparam int HueTurn    = 23040;
  localparam int SatScale   = 4096;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  sat;
    logic [ChanW-1:0] value;
  } hsv_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [ChanW-1:0] red_i        = '0;
  logic [ChanW-1:0] green_i      = '0;
  logic [ChanW-1:0] blue_i       = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [HueW-1:0]  hue_o;
  logic [SatW-1:0]  saturation_o;
  logic [ChanW-1:0] brightness_o;

  hsv_t        pending_hsv[$];
  hsv_t        want_hsv;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned ready_calm  = 0;
  int unsigned send_calm   = 0;

  rgb_to_hsv u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  always #10 clk_i = ~clk_i;

  // rounds toward minus infinity, den is always positive here
  function automatic int floor_quot(input int num, input int den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  function automatic hsv_t hsv_of_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                                        input logic [ChanW-1:0] b);
    int      rr, gg, bb, top, low, span, h, s;
    sector_e sec;
    hsv_t    res;
    rr = int'(r);
    gg = int'(g);
    bb = int'(b);
    top = rr;
    low = rr;
    if (gg > top) top = gg;
    if (bb > top) top = bb;
    if (gg < low) low = gg;
    if (bb < low) low = bb;
    span = top - low;
    h = 0;
    s = 0;
    // red wins ties, then green
    if (rr >= gg && rr >= bb) begin
      sec = SecRed;
    end else if (gg >= bb) begin
      sec = SecGreen;
    end else begin
      sec = SecBlue;
    end
    if (span > 0) begin
      case (sec)
        SecRed: begin
          h = floor_quot(HueSpan * (gg - bb), span);
        end
        SecGreen: begin
          h = floor_quot(HueSpan * (bb - rr), span) + GreenStart;
        end
        default: begin
          h = floor_quot(HueSpan * (rr - gg), span) + BlueStart;
        end
      endcase
      if (h < 0) h += HueTurn;
      s = (span * SatScale) / top;
    end
    res.hue   = h[HueW-1:0];
    res.sat   = s[SatW-1:0];
    res.value = top[ChanW-1:0];
    return res;
  endfunction

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // output side: random stalls with calm stretches in between
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (ready_calm != 0) begin
        ready_calm--;
      end else if ($urandom_range(0, 99) < 3) begin
        ready_calm = $urandom_range(30, 120);
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: result with nothing pending, got hue %0d sat %0d value %0d",
                 $time, hue_o, saturation_o, brightness_o);
        errors++;
      end else begin
        want_hsv = pending_hsv.pop_front();
        if (hue_o !== want_hsv.hue) begin
          $display("%0t: hue mismatch, expected %0d, got %0d", $time, want_hsv.hue, hue_o);
          errors++;
        end
        if (saturation_o !== want_hsv.sat) begin
          $display("%0t: saturation mismatch, expected %0d, got %0d",
                   $time, want_hsv.sat, saturation_o);
          errors++;
        end
        if (brightness_o !== want_hsv.value) begin
          $display("%0t: brightness mismatch, expected %0d, got %0d",
                   $time, want_hsv.value, brightness_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_hsv.size());
      $display("status: fail");
      $finish;
    end
  end

  // leaves valid high so back-to-back items need no extra step
  task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                            input logic [ChanW-1:0] b);
    int unsigned gap;
    if (send_calm != 0) begin
      gap = 0;
      send_calm--;
    end else if ($urandom_range(0, 99) < 3) begin
      gap = 0;
      send_calm = $urandom_range(20, 80);
    end else if ($urandom_range(0, 99) < 55) begin
      gap = 0;
    end else begin
      gap = idle_len();
    end
    @(negedge clk_i);
    if (gap != 0) begin
      // garbage on the bus while valid is low
      in_valid_i <= 1'b0;
      red_i      <= ChanW'($urandom);
      green_i    <= ChanW'($urandom);
      blue_i     <= ChanW'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_hsv.push_back(hsv_of_pixel(r, g, b));
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corner_pixels();
    logic [3*ChanW-1:0] corners [20];
    corners = '{
      24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
      24'hffff00, 24'h00ffff, 24'hff00ff, 24'hff0001, 24'h0ac800, 24'h0005c8,
      24'h010000, 24'h000100, 24'h000001, 24'hfffefe, 24'h010100, 24'hff0100,
      24'h7f80ff, 24'h01fe00
    };
    foreach (corners[i]) begin
      send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
    end
  endtask

  task automatic send_random_pixel();
    int unsigned      kind, base;
    logic [ChanW-1:0] ch [3];
    logic [1:0]       pick;
    kind = $urandom_range(0, 99);
    pick = 2'($urandom_range(0, 2));
    if (kind < 60) begin
      foreach (ch[i]) ch[i] = ChanW'($urandom);
    end else if (kind < 75) begin
      // near gray, tiny delta
      base = $urandom_range(2, 253);
      foreach (ch[i]) ch[i] = ChanW'(base + $urandom_range(0, 4) - 2);
    end else if (kind < 90) begin
      // two channels equal to exercise the sector tie rules
      base = $urandom_range(0, 255);
      foreach (ch[i]) ch[i] = ChanW'(base);
      ch[pick] = ChanW'($urandom);
    end else begin
      foreach (ch[i]) ch[i] = $urandom_range(0, 1) ? '1 : '0;
      ch[pick] = ChanW'($urandom);
    end
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  task automatic test_random_pixels(input int unsigned count);
    repeat (count) send_random_pixel();
  endtask

  // burst, then the input sits idle until the pipeline has emptied
  task automatic test_drain_pause();
    repeat (16) send_random_pixel();
    hold_until_drained();
    send_pixel('1, '0, '1);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_pixels();
    test_random_pixels(270);
    test_drain_pause();
    test_random_pixels(270);
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
